// File: hdl/vsg_pkg.sv
`timescale 1ns / 1ps
package vsg_pkg;

    localparam int unsigned PROB_W = 16;
    localparam int unsigned SPAN_W = 31;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned OUT_POS_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_MARGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOP_SIZE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEECH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SILENCE = 3'd4;

    localparam logic [PROB_W-1:0] RST_THRESHOLD = 16'd32768;
    localparam logic [PROB_W-1:0] RST_RELEASE_MARGIN = 16'd9830;
    localparam logic [PROB_W-1:0] RST_HOP_SIZE = 16'd512;
    localparam logic [SPAN_W-1:0] RST_MIN_SPEECH = 31'd4000;
    localparam logic [SPAN_W-1:0] RST_MIN_SILENCE = 31'd8000;

    typedef struct packed {
        logic [PROB_W-1:0] threshold;
        logic [PROB_W-1:0] release_margin;
        logic [PROB_W-1:0] hop_size;
        logic [SPAN_W-1:0] min_speech_samples;
        logic [SPAN_W-1:0] min_silence_samples;
    } t_cfg;

    typedef struct packed {
        logic fire;
        logic advance;
    } t_pipe_ctrl;

endpackage

// File: hdl/vad_speech_gate.sv
`timescale 1ns / 1ps
// Channel  Handshake                    Payload
// in       i_in_valid / o_in_stall      i_speech_probability[15:0], i_restart
// out      o_out_valid / i_out_stall    o_speech, o_position[31:0]
// cfg      i_cfg_we                     i_cfg_index[2:0], i_cfg_data[30:0]
//
// One item per cycle sustained while the output is not stalled; each item passes
// through the input register, then the gate logic into the result register.
// Synchronous active-low reset clears valids, gate state and config registers to defaults.
// An output stall freezes both stages; the input register still takes an item when empty.
module vad_speech_gate
    import vsg_pkg::*;
#(
    parameter int unsigned POSITION_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SPAN_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [PROB_W-1:0]    i_speech_probability,
    input  logic                 i_restart,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_speech,
    output logic [OUT_POS_W-1:0] o_position
);

    t_cfg              cfg;
    t_pipe_ctrl        ctrl;
    logic              advance;
    logic              r_in_valid;
    logic [PROB_W-1:0] r_prob;
    logic              r_restart;
    logic              in_accept;

    assign advance = !(o_out_valid && i_out_stall);
    assign ctrl = '{fire: r_in_valid && advance, advance: advance};
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (ctrl.fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_prob <= i_speech_probability;
            r_restart <= i_restart;
        end
    end

    vsg_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    vsg_gate_core #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_ctrl     (ctrl),
        .i_prob     (r_prob),
        .i_restart  (r_restart),
        .o_valid    (o_out_valid),
        .o_speech   (o_speech),
        .o_position (o_position)
    );

endmodule

// File: hdl/vsg_cfg_regs.sv
`timescale 1ns / 1ps
module vsg_cfg_regs
    import vsg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SPAN_W-1:0]    i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THRESHOLD:      n_cfg.threshold = i_cfg_data[PROB_W-1:0];
                CFG_RELEASE_MARGIN: n_cfg.release_margin = i_cfg_data[PROB_W-1:0];
                CFG_HOP_SIZE:       n_cfg.hop_size = i_cfg_data[PROB_W-1:0];
                CFG_MIN_SPEECH:     n_cfg.min_speech_samples = i_cfg_data;
                CFG_MIN_SILENCE:    n_cfg.min_silence_samples = i_cfg_data;
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= RST_THRESHOLD;
            r_cfg.release_margin <= RST_RELEASE_MARGIN;
            r_cfg.hop_size <= RST_HOP_SIZE;
            r_cfg.min_speech_samples <= RST_MIN_SPEECH;
            r_cfg.min_silence_samples <= RST_MIN_SILENCE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hdl/vsg_gate_core.sv
`timescale 1ns / 1ps
module vsg_gate_core
    import vsg_pkg::*;
#(
    parameter int unsigned POSITION_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  t_pipe_ctrl           i_ctrl,
    input  logic [PROB_W-1:0]    i_prob,
    input  logic                 i_restart,
    output logic                 o_valid,
    output logic                 o_speech,
    output logic [OUT_POS_W-1:0] o_position
);

    localparam int unsigned PW = POSITION_WIDTH;
    localparam int unsigned CW = (PW > SPAN_W) ? PW : SPAN_W;

    logic          r_active;
    logic [PW-1:0] r_pos;
    logic [PW-1:0] r_onset;
    logic [PW-1:0] r_offset;
    logic          r_valid;
    logic          r_speech;
    logic [OUT_POS_W-1:0] r_out_pos;

    logic          n_active;
    logic [PW-1:0] n_pos;
    logic [PW-1:0] n_onset;
    logic [PW-1:0] n_offset;
    logic          n_speech;

    logic          above;
    logic          below;
    logic          hold;
    logic [PW-1:0] step_pos;
    logic [PW-1:0] eff_offset;
    logic [PW-1:0] diff_on;
    logic [PW-1:0] diff_off;
    logic          onset_short;
    logic          offset_short;

    always_comb begin
        above = i_prob > i_cfg.threshold;
        below = i_prob < i_cfg.threshold;
        hold = ({1'b0, i_prob} + {1'b0, i_cfg.release_margin}) > {1'b0, i_cfg.threshold};
        step_pos = r_pos + PW'(i_cfg.hop_size);
        eff_offset = (r_offset == '0) ? step_pos : r_offset;
        diff_on = step_pos - r_onset;
        diff_off = step_pos - eff_offset;
        onset_short = CW'(diff_on) < CW'(i_cfg.min_speech_samples);
        offset_short = CW'(diff_off) < CW'(i_cfg.min_silence_samples);

        n_active = r_active;
        n_pos = step_pos;
        n_onset = r_onset;
        n_offset = r_offset;
        n_speech = 1'b0;

        if (i_restart) begin
            n_active = 1'b0;
            n_pos = '0;
            n_onset = '0;
            n_offset = '0;
        end else begin
            if (above && (r_offset != '0)) begin
                n_offset = '0;
            end
            if (above && (r_onset == '0)) begin
                n_onset = step_pos;
            end else if (above && !r_active) begin
                if (!onset_short) begin
                    n_active = 1'b1;
                    n_speech = 1'b1;
                end
            end else if (below && !r_active) begin
                n_onset = '0;
                n_offset = '0;
            end else if (r_active && hold) begin
                n_speech = 1'b1;
            end else if (below && r_active) begin
                n_offset = eff_offset;
                if (offset_short) begin
                    n_speech = 1'b1;
                end else begin
                    n_onset = '0;
                    n_offset = '0;
                    n_active = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos <= '0;
            r_onset <= '0;
            r_offset <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_ctrl.fire) begin
                r_active <= n_active;
                r_pos <= n_pos;
                r_onset <= n_onset;
                r_offset <= n_offset;
                r_valid <= 1'b1;
            end else if (i_ctrl.advance) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.fire) begin
            r_speech <= n_speech;
            r_out_pos <= OUT_POS_W'(n_pos);
        end
    end

    assign o_valid = r_valid;
    assign o_speech = r_speech;
    assign o_position = r_out_pos;

`ifndef SYNTHESIS
    a_active_has_onset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_onset != '0))
        else $error("active without onset mark");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.fire && i_restart) |=> (r_pos == '0) && !r_active && !r_speech)
        else $error("restart did not clear state");

    a_state_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctrl.fire |=> $stable(r_pos) && $stable(r_active))
        else $error("state changed without an item");

    a_speech_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_speech) |-> r_active)
        else $error("speech reported while inactive");
`endif

endmodule

// File: dv/vad_speech_gate_tb.sv
`timescale 1ns / 1ps
module vad_speech_gate_tb;
    import vsg_pkg::*;

    localparam int unsigned POS_W = 32;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned MAX_REPORTS = 100;

    typedef enum {LVL_ABOVE, LVL_BELOW, LVL_IN_MARGIN, LVL_AT_THRESHOLD, LVL_NOISE} level_e;

    class gate_scoreboard;
        typedef struct {
            logic                 speech;
            logic [OUT_POS_W-1:0] position;
        } window_result_t;

        t_cfg             regs;
        bit               active;
        bit [POS_W-1:0]   position;
        bit [POS_W-1:0]   onset_mark;
        bit [POS_W-1:0]   offset_mark;
        window_result_t   expected_q[$];
        int unsigned      errors;

        function new();
            regs = '{RST_THRESHOLD, RST_RELEASE_MARGIN, RST_HOP_SIZE,
                     RST_MIN_SPEECH, RST_MIN_SILENCE};
            clear_gate();
            errors = 0;
        endfunction

        function void clear_gate();
            active = 1'b0;
            position = '0;
            onset_mark = '0;
            offset_mark = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SPAN_W-1:0] data);
            case (idx)
                CFG_THRESHOLD: regs.threshold = data[PROB_W-1:0];
                CFG_RELEASE_MARGIN: regs.release_margin = data[PROB_W-1:0];
                CFG_HOP_SIZE: regs.hop_size = data[PROB_W-1:0];
                CFG_MIN_SPEECH: regs.min_speech_samples = data;
                CFG_MIN_SILENCE: regs.min_silence_samples = data;
                default: ;
            endcase
        endfunction

        function bit gate_window(logic [PROB_W-1:0] prob);
            bit above;
            bit below;
            above = prob > regs.threshold;
            below = prob < regs.threshold;
            position = position + POS_W'(regs.hop_size);
            if (above && offset_mark != 0)
                offset_mark = '0;
            if (above && onset_mark == 0) begin
                onset_mark = position;
                return 1'b0;
            end
            if (above && !active) begin
                if (POS_W'(position - onset_mark) < regs.min_speech_samples)
                    return 1'b0;
                active = 1'b1;
                return 1'b1;
            end
            if (below && !active) begin
                onset_mark = '0;
                offset_mark = '0;
                return 1'b0;
            end
            if (active && (17'(prob) + 17'(regs.release_margin)) > 17'(regs.threshold))
                return 1'b1;
            if (below && active) begin
                if (offset_mark == 0)
                    offset_mark = position;
                if (POS_W'(position - offset_mark) < regs.min_silence_samples)
                    return 1'b1;
                onset_mark = '0;
                offset_mark = '0;
                active = 1'b0;
                return 1'b0;
            end
            return 1'b0;
        endfunction

        function void note_window(logic [PROB_W-1:0] prob, logic restart);
            window_result_t res;
            if (restart) begin
                clear_gate();
                res.speech = 1'b0;
            end else begin
                res.speech = gate_window(prob);
            end
            res.position = OUT_POS_W'(position);
            expected_q.push_back(res);
        endfunction

        function void flag(string msg);
            if (errors < MAX_REPORTS)
                $error("%s", msg);
            errors++;
        endfunction

        function void check_window(logic speech, logic [OUT_POS_W-1:0] pos);
            window_result_t want;
            if (expected_q.size() == 0) begin
                flag($sformatf("unexpected result: speech %0d, position %0d", speech, pos));
                return;
            end
            want = expected_q.pop_front();
            if (speech !== want.speech)
                flag($sformatf("speech: expected %0d, actual %0d", want.speech, speech));
            if (pos !== want.position)
                flag($sformatf("position: expected %0d, actual %0d", want.position, pos));
        endfunction
    endclass

    logic                 i_clk;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SPAN_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [PROB_W-1:0]    speech_prob = '0;
    logic                 restart_in = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 speech_out;
    logic [OUT_POS_W-1:0] position_out;

    gate_scoreboard sb;
    int unsigned    sender_idle_pct = 0;
    int unsigned    stall_pct = 0;
    int unsigned    quiet_cycles = 0;
    int unsigned    burst_left = 0;
    level_e         burst_level = LVL_NOISE;

    vad_speech_gate #(
        .POSITION_WIDTH(POS_W)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(rst_n),
        .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_speech_probability(speech_prob),
        .i_restart(restart_in),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_speech(speech_out),
        .o_position(position_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                sb.check_window(speech_out, position_out);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SPAN_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic program_gate(input t_cfg c);
        write_reg(CFG_THRESHOLD, {15'($urandom), c.threshold});
        write_reg(CFG_RELEASE_MARGIN, {15'($urandom), c.release_margin});
        write_reg(CFG_HOP_SIZE, {15'($urandom), c.hop_size});
        write_reg(CFG_MIN_SPEECH, c.min_speech_samples);
        write_reg(CFG_MIN_SILENCE, c.min_silence_samples);
        write_reg(CFG_IDX_W'(CFG_MIN_SILENCE + 1 + $urandom_range(0, 2)), SPAN_W'($urandom));
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_window(input logic [PROB_W-1:0] prob, input logic restart);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        speech_prob <= prob;
        restart_in <= restart;
        do @(posedge i_clk); while (in_stall);
        sb.note_window(prob, restart);
    endtask

    task automatic send_random_window(input bit allow_restart);
        int thr;
        int mrg;
        int lo;
        int hi;
        int pick;
        thr = sb.regs.threshold;
        mrg = sb.regs.release_margin;
        if (burst_left == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                burst_level = LVL_ABOVE;
            else if (pick < 65)
                burst_level = LVL_BELOW;
            else if (pick < 80)
                burst_level = LVL_IN_MARGIN;
            else if (pick < 85)
                burst_level = LVL_AT_THRESHOLD;
            else
                burst_level = LVL_NOISE;
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        case (burst_level)
            LVL_ABOVE: begin
                lo = (thr < 65535) ? thr + 1 : 65535;
                hi = 65535;
            end
            LVL_BELOW: begin
                lo = 0;
                hi = (thr > 0) ? thr - 1 : 0;
            end
            LVL_IN_MARGIN: begin
                hi = (thr > 0) ? thr - 1 : 0;
                lo = thr - mrg + 1;
                if (lo < 0)
                    lo = 0;
                if (lo > hi)
                    lo = hi;
            end
            LVL_AT_THRESHOLD: begin
                lo = thr;
                hi = thr;
            end
            default: begin
                lo = 0;
                hi = 65535;
            end
        endcase
        send_window(PROB_W'($urandom_range(hi, lo)),
                    allow_restart && ($urandom_range(0, 99) < 2));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    function automatic logic [SPAN_W-1:0] random_span(int unsigned win);
        if ($urandom_range(0, 99) < 85)
            return SPAN_W'(win * $urandom_range(0, 8) + $urandom_range(0, win));
        return SPAN_W'($urandom);
    endfunction

    function automatic t_cfg random_settings(int unsigned kind);
        t_cfg c;
        case (kind)
            0: c = '{16'd0, 16'd0, 16'd1, 31'd0, 31'd0};
            1: c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF};
            default: begin
                c.threshold = PROB_W'($urandom);
                if ($urandom_range(0, 99) < 20)
                    c.release_margin = PROB_W'($urandom);
                else
                    c.release_margin = PROB_W'($urandom_range(0, 12000));
                if ($urandom_range(0, 99) < 70)
                    c.hop_size = PROB_W'($urandom_range(1, 1024));
                else
                    c.hop_size = PROB_W'($urandom_range(1, 65535));
                c.min_speech_samples = random_span(c.hop_size);
                c.min_silence_samples = random_span(c.hop_size);
            end
        endcase
        return c;
    endfunction

    initial begin
        t_cfg        c;
        sb = new();
        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        program_gate('{16'd32768, 16'd9830, 16'd512, 31'd1024, 31'd1024});
        send_window(16'd32768, 1'b0);
        send_window(16'd0, 1'b0);
        send_window(16'd65535, 1'b0);
        send_window(16'd40000, 1'b0);
        send_window(16'd40000, 1'b0);
        send_window(16'd32768, 1'b0);
        send_window(16'd30000, 1'b0);
        send_window(16'd20000, 1'b0);
        send_window(16'd20000, 1'b0);
        send_window(16'd20000, 1'b0);
        send_window(16'd65535, 1'b0);
        send_window(16'd65535, 1'b0);
        send_window(16'd65535, 1'b0);
        send_window(16'd0, 1'b0);
        send_window(16'd0, 1'b0);
        send_window(16'd0, 1'b0);
        send_window(16'd65535, 1'b1);
        send_window(16'd0, 1'b1);
        send_window(16'd65535, 1'b0);
        drain();

        // margin wider than the threshold holds speech at any level
        program_gate('{16'd1000, 16'd2000, 16'd512, 31'd0, 31'd512});
        send_window(16'd65535, 1'b0);
        send_window(16'd65535, 1'b0);
        send_window(16'd0, 1'b0);
        send_window(16'd0, 1'b0);
        send_window(16'd0, 1'b1);
        drain();

        for (int mode = 0; mode < 3; mode++) begin
            sender_idle_pct = (mode == 0) ? 32 : (mode == 1) ? 52 : 0;
            stall_pct = (mode == 0) ? 52 : (mode == 1) ? 32 : 0;
            for (int k = 0; k < 6; k++) begin
                program_gate(random_settings(k));
                repeat (80) send_random_window(1'b1);
                drain();
            end
        end

        // pin the position at zero so an onset mark lands on zero and stays unset
        program_gate('{16'd32768, 16'd0, 16'd0, 31'd0, 31'd0});
        send_window(16'd0, 1'b1);
        send_window(16'd65535, 1'b0);
        send_window(16'd65535, 1'b0);
        send_window(16'd0, 1'b0);
        drain();
        c = '{16'd32768, PROB_W'($urandom_range(0, 12000)), 16'hFFFF,
              SPAN_W'(65535 * $urandom_range(0, 6)), SPAN_W'(65535 * $urandom_range(0, 6))};
        program_gate(c);
        repeat (200) send_random_window(1'b1);
        drain();

        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
hdl/vsg_pkg.sv
hdl/vsg_cfg_regs.sv
hdl/vsg_gate_core.sv
hdl/vad_speech_gate.sv
dv/vad_speech_gate_tb.sv
